/* hw/rtl/dqr_pkg.sv */
package dqr_pkg;

  // Operation codes carried in the mode field of a request.
  localparam logic [2:0] MODE_PUSH_BACK  = 3'd0;
  localparam logic [2:0] MODE_PUSH_FRONT = 3'd1;
  localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [2:0] MODE_POP_BACK   = 3'd3;
  localparam logic [2:0] MODE_REVERSE    = 3'd4;

  // Result status codes.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam int WORD_W = 32;

  typedef logic signed [WORD_W-1:0] word_t;

  // Physical ring operation after the reverse flag has been applied.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUSH_HEAD,
    OP_PUSH_TAIL,
    OP_POP_HEAD,
    OP_POP_TAIL,
    OP_TOGGLE,
    OP_FAIL_EMPTY,
    OP_FAIL_FULL
  } dq_op_t;

  typedef enum logic {
    ST_IDLE,
    ST_HOLD
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic   take;
    dq_op_t op;
    logic   load_res;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
    logic reversed;
    logic res_free;
  } dp_stat_t;

endpackage

/* hw/rtl/dqr_req_if.sv */
interface dqr_req_if;
  import dqr_pkg::*;

  logic       valid;
  logic       ready;
  logic [2:0] mode;
  word_t      value;

  modport source (output valid, output mode, output value, input ready);
  modport sink (input valid, input mode, input value, output ready);
endinterface

/* hw/rtl/dqr_rsp_if.sv */
interface dqr_rsp_if;
  import dqr_pkg::*;

  logic       valid;
  logic       ready;
  word_t      value_res;
  logic [1:0] status;

  modport source (output valid, output value_res, output status, input ready);
  modport sink (input valid, input value_res, input status, output ready);
endinterface

/* hw/rtl/dqr_ctrl.sv */
module dqr_ctrl (
  input  logic               clk,
  input  logic               rst,
  dqr_req_if.sink            req,
  input  dqr_pkg::dp_stat_t  stat,
  output dqr_pkg::dp_cmd_t   cmd
);
  import dqr_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;
  dq_op_t      op;
  logic        has_result;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Map the requested mode onto a physical ring operation.
  always_comb begin
    case (req.mode)
      MODE_PUSH_BACK: begin
        op = stat.full ? OP_FAIL_FULL : (stat.reversed ? OP_PUSH_HEAD : OP_PUSH_TAIL);
      end
      MODE_PUSH_FRONT: begin
        op = stat.full ? OP_FAIL_FULL : (stat.reversed ? OP_PUSH_TAIL : OP_PUSH_HEAD);
      end
      MODE_POP_FRONT: begin
        op = stat.empty ? OP_FAIL_EMPTY : (stat.reversed ? OP_POP_TAIL : OP_POP_HEAD);
      end
      MODE_POP_BACK: begin
        op = stat.empty ? OP_FAIL_EMPTY : (stat.reversed ? OP_POP_HEAD : OP_POP_TAIL);
      end
      MODE_REVERSE: begin
        op = OP_TOGGLE;
      end
      default: begin
        op = OP_NONE;
      end
    endcase
    has_result = (op == OP_POP_HEAD) || (op == OP_POP_TAIL) ||
                 (op == OP_FAIL_EMPTY) || (op == OP_FAIL_FULL);
  end

  // Next state and commands. A result waits in HOLD until the output register is free.
  always_comb begin
    state_next   = state;
    req.ready    = 1'b0;
    cmd.take     = 1'b0;
    cmd.op       = op;
    cmd.load_res = 1'b0;
    case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          cmd.take = 1'b1;
          if (has_result) begin
            state_next = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        cmd.load_res = stat.res_free;
        if (stat.res_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/dqr_datapath.sv */
module dqr_datapath #(
  parameter int DEPTH = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  dqr_pkg::dp_cmd_t  cmd,
  input  dqr_pkg::word_t    value,
  output dqr_pkg::dp_stat_t stat,
  dqr_rsp_if.source         rsp
);
  import dqr_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  word_t          mem [DEPTH];
  word_t          rdata;
  logic [IW-1:0]  head;
  logic [CW-1:0]  count;
  logic           reversed;
  logic [1:0]     pend_status;
  logic           res_valid;

  logic [SW-1:0]  end_sum;
  logic [SW-1:0]  last_sum;
  logic [IW-1:0]  tail_addr;
  logic [IW-1:0]  last_addr;
  logic [IW-1:0]  head_dec;
  logic [IW-1:0]  head_inc;
  logic           we;
  logic [IW-1:0]  waddr;
  logic           re;
  logic [IW-1:0]  raddr;

  // Ring address arithmetic; end_sum stays below twice the depth, and last_sum does too while the ring is not empty.
  always_comb begin
    end_sum   = SW'(head) + SW'(count);
    last_sum  = end_sum - SW'(1);
    tail_addr = (end_sum >= SW'(DEPTH)) ? IW'(end_sum - SW'(DEPTH)) : IW'(end_sum);
    last_addr = (last_sum >= SW'(DEPTH)) ? IW'(last_sum - SW'(DEPTH)) : IW'(last_sum);
    head_dec  = (head == '0) ? IW'(DEPTH - 1) : head - IW'(1);
    head_inc  = (head == IW'(DEPTH - 1)) ? '0 : head + IW'(1);
  end

  // Memory port selection.
  always_comb begin
    we    = cmd.take && ((cmd.op == OP_PUSH_HEAD) || (cmd.op == OP_PUSH_TAIL));
    waddr = (cmd.op == OP_PUSH_HEAD) ? head_dec : tail_addr;
    re    = cmd.take && ((cmd.op == OP_POP_HEAD) || (cmd.op == OP_POP_TAIL));
    raddr = (cmd.op == OP_POP_HEAD) ? head : last_addr;
  end

  // Ring storage with a registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= value;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  // Head pointer, occupancy and reverse flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      count    <= '0;
      reversed <= 1'b0;
    end else if (cmd.take) begin
      case (cmd.op)
        OP_PUSH_HEAD: begin
          head  <= head_dec;
          count <= count + CW'(1);
        end
        OP_PUSH_TAIL: begin
          count <= count + CW'(1);
        end
        OP_POP_HEAD: begin
          head  <= head_inc;
          count <= count - CW'(1);
        end
        OP_POP_TAIL: begin
          count <= count - CW'(1);
        end
        OP_TOGGLE: begin
          reversed <= ~reversed;
        end
        default: begin
        end
      endcase
    end
  end

  // Status of a result that is waiting for the output register.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      case (cmd.op)
        OP_FAIL_EMPTY: pend_status <= STATUS_EMPTY;
        OP_FAIL_FULL:  pend_status <= STATUS_FULL;
        default:       pend_status <= STATUS_OK;
      endcase
    end
  end

  // Output register; a transfer frees it.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load_res) begin
      res_valid <= 1'b1;
    end else if (rsp.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_res) begin
      rsp.value_res <= (pend_status == STATUS_OK) ? rdata : '0;
      rsp.status    <= pend_status;
    end
  end

  assign rsp.valid = res_valid;

  assign stat.empty    = (count == '0);
  assign stat.full     = (count == CW'(DEPTH));
  assign stat.reversed = reversed;
  assign stat.res_free = !res_valid || rsp.ready;

endmodule

/* hw/rtl/deque_with_reverse_top.sv */
// Channel  Modport  Payload                                    Purpose
// req      sink     mode[2:0], value[31:0] signed              operations in
// rsp      source   value_res[31:0] signed, status[1:0]        pop and error results out
//
// A push, a reverse toggle or an unused mode leaves the controller idle; the next request
// is accepted in the following cycle.
// A pop or a failed operation first reads the ring memory through its registered read port
// or notes the failure status, then waits in HOLD until it can load the output register.
// A result is held back while the output register is occupied and not being drained;
// requests are then stalled. Reset (rst, synchronous) empties the ring and clears reverse.
module deque_with_reverse_top #(
  parameter int DEPTH = 1024
) (
  input  logic     clk,
  input  logic     rst,
  dqr_req_if.sink  req,
  dqr_rsp_if.source rsp
);
  import dqr_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  dqr_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .stat (stat),
    .cmd  (cmd)
  );

  dqr_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .value (req.value),
    .stat  (stat),
    .rsp   (rsp)
  );

  // A push never reaches the ring while it is full.
  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.take && ((cmd.op == OP_PUSH_HEAD) || (cmd.op == OP_PUSH_TAIL)) |-> !stat.full)
    else $error("push issued to a full ring");

  // A pop never reads the ring while it is empty.
  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.take && ((cmd.op == OP_POP_HEAD) || (cmd.op == OP_POP_TAIL)) |-> !stat.empty)
    else $error("pop issued to an empty ring");

  // A loaded result is presented in the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_res |=> rsp.valid)
    else $error("loaded result not presented");

  // A request is never taken in the same cycle that a result is loaded.
  a_no_take_with_load: assert property (@(posedge clk) disable iff (rst)
    !(cmd.take && cmd.load_res))
    else $error("request taken while a result is loaded");

endmodule
